FILE: rtl/core/awrt_pkg.sv
// Package: shared types, constants and codes of the ack wait retransmit table.
package awrt_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 8;
  localparam int TYPE_W   = 4;
  localparam int TRIES_W  = 4;
  localparam int CD_W     = 16;
  localparam logic [TRIES_W-1:0] TRIES_MAX = '1;

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_ACK      = 2'd1,
    ACT_NEEDMORE = 2'd2,
    ACT_TICK     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    K_ADDED    = 3'd0,
    K_FULL     = 3'd1,
    K_ACKED    = 3'd2,
    K_ACK_MISS = 3'd3,
    K_EXTENDED = 3'd4,
    K_REFUSED  = 3'd5,
    K_RETX     = 3'd6,
    K_GIVEUP   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_TRIES   = 2'd1,
    REG_EXTTYPE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] buffer_handle;
    logic [TYPE_W-1:0]   msg_type;
  } in_word_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [KEY_W-1:0]    key_out;
    logic [HANDLE_W-1:0] handle_out;
    logic [TYPE_W-1:0]   type_out;
    logic                last;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [TYPE_W-1:0]   ctype;
    logic [HANDLE_W-1:0] handle;
    logic [TRIES_W-1:0]  tries;
    logic [CD_W-1:0]     countdown;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/core/awrt_ram.sv
// Single write port, single registered read port RAM.
module awrt_ram #(
  parameter int W     = 8,
  parameter int WORDS = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/ack_wait_retransmit_table_unit.sv
// Top level: ack wait retransmit table with entry RAM, sweep FSM and APB registers.
//
// Input channel in_valid/in_stall/in_data carries one request word: add, ack,
// needmore or tick. Result channel out_valid/out_stall/out_data returns result
// words; the final word of a request has last set. Add, ack and needmore give
// exactly one word; a tick gives one word per expiring entry, in entry order,
// or none at all.
// A request is taken only while the block is idle; a finished result may still
// sit in the output register at that time. Ack and needmore walk the entry RAM
// one entry per cycle and stop at the first match or the last entry, where they
// wait while the receiver stalls. A tick walks all 16 entries, reading one and
// writing back the previous each cycle unless the receiver stalls. The RAM port
// that serves one entry per cycle sets this pace.
// A tick holds one expired result back so that last can be marked; when the
// receiver stalls, the walk pauses on the entry that has a result to hand on.
// Reset clears all entry valid bits and loads the registers with 100, 3 and 1;
// entry contents need no clearing. Registers are written over APB at byte addresses
// 0, 4 and 8; the user must do so only while the block is idle (not enforced).
module ack_wait_retransmit_table_unit
  import awrt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [3:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [CD_W-1:0]    timeout_r;
  logic [TRIES_W-1:0] max_tries_r;
  logic [TYPE_W-1:0]  ext_type_r;
  reg_idx_t           cfg_idx;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= CD_W'(100);
      max_tries_r <= TRIES_W'(3);
      ext_type_r  <= TYPE_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TIMEOUT: timeout_r   <= cfg_pwdata[CD_W-1:0];
        REG_TRIES:   max_tries_r <= cfg_pwdata[TRIES_W-1:0];
        REG_EXTTYPE: ext_type_r  <= cfg_pwdata[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TIMEOUT: cfg_prdata = 32'(timeout_r);
      REG_TRIES:   cfg_prdata = 32'(max_tries_r);
      REG_EXTTYPE: cfg_prdata = 32'(ext_type_r);
      default:     cfg_prdata = '0;
    endcase
  end

  state_t           state_r, state_nxt;
  in_word_t         req_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [DEPTH-1:0] valid_r, valid_nxt;
  out_word_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;

  logic             we_c;
  logic [IDX_W-1:0] waddr_c, raddr_c;
  entry_t           wdata_c, q;
  logic             out_free, at_end, advance;
  logic             hit, ent_v, expire, giveup, has_free;
  logic [IDX_W-1:0] free_idx;
  logic [TRIES_W-1:0] new_tries;
  out_word_t        res_c;
  logic             accept;

  awrt_ram #(.W(ENTRY_W), .WORDS(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we_c),
    .waddr (waddr_c),
    .wdata (wdata_c),
    .raddr (raddr_c),
    .rdata (q)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign at_end    = (idx_r == IDX_W'(DEPTH - 1));
  assign ent_v     = valid_r[idx_r];
  assign hit       = ent_v && (q.key == req_r.key);
  assign expire    = ent_v && (q.countdown <= CD_W'(1));
  assign new_tries = (q.tries < TRIES_MAX) ? q.tries + TRIES_W'(1) : q.tries;
  assign giveup    = new_tries >= max_tries_r;

  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        has_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Walk step: whether the current entry is finished this cycle.
  always_comb begin
    advance = 1'b0;
    if (state_r == ST_SCAN) begin
      if (action_t'(req_r.action) == ACT_TICK) begin
        advance = !(expire && pend_v_r && !out_free);
      end else begin
        advance = !hit && !at_end;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (action_t'(in_data.action) == ACT_ADD) ? ST_ADD : ST_SCAN;
        end
      end
      ST_ADD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (action_t'(req_r.action) == ACT_TICK) begin
          if (advance && at_end) state_nxt = ST_DONE;
        end else if ((hit || at_end) && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!pend_v_r || out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    idx_nxt       = idx_r;
    valid_nxt     = valid_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    we_c          = 1'b0;
    waddr_c       = idx_r;
    wdata_c       = q;
    raddr_c       = '0;
    res_c         = '0;
    res_c.key_out = req_r.key;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
      end
      ST_ADD: begin
        if (out_free) begin
          res_c.kind       = has_free ? K_ADDED : K_FULL;
          res_c.handle_out = req_r.buffer_handle;
          res_c.type_out   = req_r.msg_type;
          res_c.last       = 1'b1;
          out_nxt          = res_c;
          out_valid_nxt    = 1'b1;
          if (has_free) begin
            we_c              = 1'b1;
            waddr_c           = free_idx;
            wdata_c.key       = req_r.key;
            wdata_c.ctype     = req_r.msg_type;
            wdata_c.handle    = req_r.buffer_handle;
            wdata_c.tries     = '0;
            wdata_c.countdown = timeout_r;
            valid_nxt[free_idx] = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        raddr_c = advance ? idx_r + IDX_W'(1) : idx_r;
        if (advance) idx_nxt = idx_r + IDX_W'(1);
        if (action_t'(req_r.action) == ACT_TICK) begin
          res_c.kind       = giveup ? K_GIVEUP : K_RETX;
          res_c.key_out    = q.key;
          res_c.handle_out = q.handle;
          res_c.type_out   = q.ctype;
          if (advance && ent_v) begin
            we_c = 1'b1;
            if (!expire) begin
              wdata_c.countdown = q.countdown - CD_W'(1);
            end else begin
              wdata_c.tries     = new_tries;
              wdata_c.countdown = timeout_r;
              if (giveup) valid_nxt[idx_r] = 1'b0;
              if (pend_v_r) begin
                out_nxt       = pend_r;
                out_valid_nxt = 1'b1;
              end
              pend_nxt   = res_c;
              pend_v_nxt = 1'b1;
            end
          end
        end else if ((hit || at_end) && out_free) begin
          res_c.last = 1'b1;
          if (hit) begin
            res_c.handle_out = q.handle;
            res_c.type_out   = q.ctype;
          end
          if (action_t'(req_r.action) == ACT_ACK) begin
            res_c.kind = hit ? K_ACKED : K_ACK_MISS;
            if (hit) valid_nxt[idx_r] = 1'b0;
          end else if (hit && q.ctype == ext_type_r) begin
            res_c.kind        = K_EXTENDED;
            we_c              = 1'b1;
            wdata_c.tries     = '0;
            wdata_c.countdown = timeout_r;
          end else begin
            res_c.kind = K_REFUSED;
          end
          out_nxt       = res_c;
          out_valid_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (pend_v_r && out_free) begin
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_r <= in_data;
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  a_pend_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (action_t'(req_r.action) == ACT_TICK &&
                  (state_r == ST_SCAN || state_r == ST_DONE)))
    else $error("held result outside a tick walk");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind != K_RETX && out_r.kind != K_GIVEUP) |-> out_r.last)
    else $error("single result word without last");

  a_add_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD && out_free) |=> (state_r == ST_IDLE && out_valid_r))
    else $error("add did not complete");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !pend_v_r) |=> state_r == ST_IDLE)
    else $error("tick walk did not finish");

endmodule

FILE: tb/sv/tb_ack_wait_retransmit_table_unit.sv
// Testbench: ack wait retransmit table, directed table plus random traffic against a predictor.
`timescale 1ns / 100ps

module tb_ack_wait_retransmit_table_unit;
  import awrt_pkg::*;

  localparam int LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ack_wait_retransmit_table_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // table mirror
  logic [15:0]         p_timeout;
  logic [3:0]          p_max_tries;
  logic [3:0]          p_ext_type;
  logic                slot_used [DEPTH];
  logic [KEY_W-1:0]    slot_key [DEPTH];
  logic [TYPE_W-1:0]   slot_type [DEPTH];
  logic [HANDLE_W-1:0] slot_handle [DEPTH];
  logic [3:0]          slot_tries [DEPTH];
  logic [15:0]         slot_cd [DEPTH];

  out_word_t pending_results [$];
  int  errors;
  int  cycles;
  bit  sender_hold;
  logic [KEY_W-1:0] live_keys [$];

  function automatic out_word_t mk(kind_t k, logic [KEY_W-1:0] key,
                                   logic [HANDLE_W-1:0] h, logic [TYPE_W-1:0] t);
    out_word_t w;
    w.kind = k; w.key_out = key; w.handle_out = h; w.type_out = t; w.last = 1'b0;
    return w;
  endfunction

  function automatic int lookup_slot(logic [KEY_W-1:0] key);
    for (int i = 0; i < DEPTH; i++)
      if (slot_used[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  task automatic predict_table(in_word_t w);
    out_word_t r [$];
    int i;
    case (action_t'(w.action))
      ACT_ADD: begin
        i = -1;
        for (int j = DEPTH - 1; j >= 0; j--) if (!slot_used[j]) i = j;
        if (i >= 0) begin
          slot_used[i] = 1'b1; slot_key[i] = w.key; slot_type[i] = w.msg_type;
          slot_handle[i] = w.buffer_handle; slot_tries[i] = '0; slot_cd[i] = p_timeout;
          r.push_back(mk(K_ADDED, w.key, w.buffer_handle, w.msg_type));
        end else
          r.push_back(mk(K_FULL, w.key, w.buffer_handle, w.msg_type));
      end
      ACT_ACK: begin
        i = lookup_slot(w.key);
        if (i >= 0) begin
          slot_used[i] = 1'b0;
          r.push_back(mk(K_ACKED, w.key, slot_handle[i], slot_type[i]));
        end else
          r.push_back(mk(K_ACK_MISS, w.key, '0, '0));
      end
      ACT_NEEDMORE: begin
        i = lookup_slot(w.key);
        if (i >= 0 && slot_type[i] == p_ext_type) begin
          slot_tries[i] = '0; slot_cd[i] = p_timeout;
          r.push_back(mk(K_EXTENDED, w.key, slot_handle[i], slot_type[i]));
        end else if (i >= 0)
          r.push_back(mk(K_REFUSED, w.key, slot_handle[i], slot_type[i]));
        else
          r.push_back(mk(K_REFUSED, w.key, '0, '0));
      end
      default: begin
        for (int j = 0; j < DEPTH; j++) begin
          if (!slot_used[j]) continue;
          if (slot_cd[j] > 1) begin
            slot_cd[j]--;
            continue;
          end
          if (slot_tries[j] != TRIES_MAX) slot_tries[j]++;
          if (slot_tries[j] >= p_max_tries) begin
            slot_used[j] = 1'b0;
            r.push_back(mk(K_GIVEUP, slot_key[j], slot_handle[j], slot_type[j]));
          end else begin
            slot_cd[j] = p_timeout;
            r.push_back(mk(K_RETX, slot_key[j], slot_handle[j], slot_type[j]));
          end
        end
      end
    endcase
    if (r.size() > 0) r[r.size() - 1].last = 1'b1;
    foreach (r[k]) pending_results.push_back(r[k]);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word kind=%0d key=%h", $time, out_data.kind,
                 out_data.key_out);
        errors++;
      end else begin
        out_word_t e;
        e = pending_results.pop_front();
        if (e !== out_data) begin
          $display({"%0t: mismatch expected k=%0d key=%h h=%h t=%h l=%b",
                    " actual k=%0d key=%h h=%h t=%h l=%b"},
                   $time, e.kind, e.key_out, e.handle_out, e.type_out, e.last,
                   out_data.kind, out_data.key_out, out_data.handle_out,
                   out_data.type_out, out_data.last);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern
  int stall_mode;
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 2) != 0);
    endcase
    if ($urandom_range(0, 60) == 0) stall_mode <= $urandom_range(0, 2);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("ack_wait_retransmit_table_unit verification failed");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_TIMEOUT: p_timeout = val[15:0];
      REG_TRIES:   p_max_tries = val[3:0];
      default:     p_ext_type = val[3:0];
    endcase
  endtask

  task automatic set_regs(logic [15:0] t, logic [3:0] m, logic [3:0] x);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    reg_write(REG_TIMEOUT, {16'h0, t});
    reg_write(REG_TRIES, {28'h0, m});
    reg_write(REG_EXTTYPE, {28'h0, x});
  endtask

  task automatic send_word(in_word_t w);
    int gap;
    if (!sender_hold && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_table(w);
    if (w.action == ACT_ADD) live_keys.push_back(w.key);
  endtask

  task automatic idle_input;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_word_t iw(action_t a, logic [31:0] k, logic [7:0] h, logic [3:0] t);
    in_word_t w;
    w.action = a; w.key = k; w.buffer_handle = h; w.msg_type = t;
    return w;
  endfunction

  // directed table; chk marks rows whose result is typed in
  typedef struct {
    in_word_t  w;
    bit        chk;
    out_word_t r;
  } step_row_t;

  step_row_t plan [$];

  task automatic add_row(in_word_t w, bit chk, out_word_t r);
    step_row_t s;
    s.w = w; s.chk = chk; s.r = r;
    plan.push_back(s);
  endtask

  task automatic run_plan;
    foreach (plan[k]) begin
      if (plan[k].chk) begin
        out_word_t e;
        send_word(plan[k].w);
        e = pending_results[$];
        if (e !== plan[k].r) begin
          $display("%0t: table row %0d expected k=%0d h=%h t=%h actual k=%0d h=%h t=%h",
                   $time, k, plan[k].r.kind, plan[k].r.handle_out, plan[k].r.type_out,
                   e.kind, e.handle_out, e.type_out);
          errors++;
        end
      end else
        send_word(plan[k].w);
    end
    plan.delete();
  endtask

  task automatic random_phase(int count, int key_span);
    in_word_t w;
    int sel;
    for (int n = 0; n < count; n++) begin
      sender_hold = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      w.key = $urandom;
      w.buffer_handle = 8'($urandom);
      w.msg_type = 4'($urandom);
      if (key_span > 0) w.key = $urandom_range(0, key_span);
      if (sel < 30) w.action = ACT_ADD;
      else if (sel < 50) w.action = ACT_ACK;
      else if (sel < 65) w.action = ACT_NEEDMORE;
      else w.action = ACT_TICK;
      if ((w.action == ACT_ACK || w.action == ACT_NEEDMORE) && live_keys.size() > 0
          && $urandom_range(0, 4) != 0)
        w.key = live_keys[$urandom_range(0, live_keys.size() - 1)];
      if (w.action == ACT_NEEDMORE && $urandom_range(0, 1) == 0)
        w.msg_type = p_ext_type;
      send_word(w);
    end
    idle_input();
  endtask

  initial begin
    errors = 0; cycles = 0; stall_mode = 0; sender_hold = 0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_data = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    p_timeout = 16'd100; p_max_tries = 4'd3; p_ext_type = 4'd1;
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 0; slot_key[i] = 0; slot_type[i] = 0;
      slot_handle[i] = 0; slot_tries[i] = 0; slot_cd[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: ack and needmore miss, empty tick, adds with extremes, needmore, acks
    add_row(iw(ACT_ACK, 32'hFFFF_FFFF, 8'hFF, 4'hF), 1,
            {K_ACK_MISS, 32'hFFFF_FFFF, 8'h00, 4'h0, 1'b1});
    add_row(iw(ACT_NEEDMORE, 32'h0, 8'h00, 4'h0), 1,
            {K_REFUSED, 32'h0, 8'h00, 4'h0, 1'b1});
    add_row(iw(ACT_TICK, 32'h0, 8'h0, 4'h0), 0, '0);
    add_row(iw(ACT_ADD, 32'hFFFF_FFFF, 8'hFF, 4'hF), 1,
            {K_ADDED, 32'hFFFF_FFFF, 8'hFF, 4'hF, 1'b1});
    add_row(iw(ACT_ADD, 32'h0, 8'h00, 4'h1), 1, {K_ADDED, 32'h0, 8'h00, 4'h1, 1'b1});
    add_row(iw(ACT_ADD, 32'h0, 8'hA5, 4'h1), 0, '0);
    add_row(iw(ACT_NEEDMORE, 32'h0, 8'h0, 4'h0), 1, {K_EXTENDED, 32'h0, 8'h00, 4'h1, 1'b1});
    add_row(iw(ACT_NEEDMORE, 32'hFFFF_FFFF, 8'h0, 4'h0), 1,
            {K_REFUSED, 32'hFFFF_FFFF, 8'hFF, 4'hF, 1'b1});
    add_row(iw(ACT_ACK, 32'h0, 8'h0, 4'h0), 1, {K_ACKED, 32'h0, 8'h00, 4'h1, 1'b1});
    add_row(iw(ACT_ACK, 32'h0, 8'h0, 4'h0), 1, {K_ACKED, 32'h0, 8'hA5, 4'h1, 1'b1});
    run_plan();

    // short timeout with one try, fill to full, then a tick
    set_regs(16'd1, 4'd1, 4'd15);
    for (int i = 0; i < DEPTH; i++)
      add_row(iw(ACT_ADD, 32'h1000 + i, i[7:0], i[3:0]), 0, '0);
    add_row(iw(ACT_ADD, 32'h5555_AAAA, 8'h5A, 4'h7), 1,
            {K_FULL, 32'h5555_AAAA, 8'h5A, 4'h7, 1'b1});
    add_row(iw(ACT_TICK, 32'h0, 8'h0, 4'h0), 0, '0);
    run_plan();

    // zero timeout, max tries zero and fifteen
    set_regs(16'd0, 4'd0, 4'd0);
    for (int i = 0; i < 3; i++) send_word(iw(ACT_ADD, 32'h77, 8'h33, 4'h0));
    send_word(iw(ACT_TICK, 32'h0, 8'h0, 4'h0));
    set_regs(16'd0, 4'd15, 4'd3);
    random_phase(60, 7);
    for (int i = 0; i < 18; i++) send_word(iw(ACT_TICK, 32'h0, 8'h0, 4'h0));
    idle_input();

    set_regs(16'd3, 4'd2, 4'd5);
    random_phase(60, 15);
    set_regs(16'hFFFF, 4'd3, 4'd1);
    random_phase(30, 0);
    set_regs(16'd2, 4'd4, 4'd2);
    random_phase(50, 31);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("ack_wait_retransmit_table_unit verification clean");
    else
      $display("ack_wait_retransmit_table_unit verification failed");
    $finish;
  end

endmodule
